@@ rtl/brnq_pkg.sv @@
// ----------------------------------------------------------------------------
// brnq_pkg
// Shared constants and types for the bilinear resize / normalize / quantize block.
// ----------------------------------------------------------------------------
package brnq_pkg;

  localparam int SOURCE_WIDTH  = 256;
  localparam int SOURCE_HEIGHT = 256;
  localparam int DEST_WIDTH    = 224;
  localparam int DEST_HEIGHT   = 224;

  localparam int ADDR_W  = 16;
  localparam int PIX_W   = 24;
  localparam int COORD_W = 24;   // 8 integer bits, 16 fraction bits

  localparam logic [0:0] OP_WRITE   = 1'b0;
  localparam logic [0:0] OP_COMPUTE = 1'b1;

  localparam logic [6:0] QUANT_RESET = 7'd64;

  // floor(u/255) = (u * RECIP_255) >> RECIP_SHIFT for u < 2^23
  localparam logic [23:0] RECIP_255   = 24'd8421505;
  localparam int          RECIP_SHIFT = 31;
  localparam logic [16:0] NORM_OFFSET = 17'd16384;

  typedef struct packed {
    logic [7:0]  i;
    logic [15:0] f;
  } coord_t;

  typedef struct packed {
    logic [PIX_W-1:0] p00;
    logic [PIX_W-1:0] p01;
    logic [PIX_W-1:0] p10;
    logic [PIX_W-1:0] p11;
  } quad_t;

endpackage

@@ rtl/bilinear_resize_normalize_quantize.sv @@
// ----------------------------------------------------------------------------
// bilinear_resize_normalize_quantize
// Timing: a write lands at its accepting edge; a compute result strobes after the
// coordinate divider register, four frame-store reads on the single port, the launch
// register and the six-stage blend pipeline.
// Throughput: one write per cycle while idle; a new compute is accepted only after the
// previous result has strobed. Receiver cannot stall; out_valid lasts one cycle.
// Reset: synchronous, clears control and sets quant_scale to 64; store is not cleared.
// ----------------------------------------------------------------------------
module bilinear_resize_normalize_quantize
  import brnq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              opcode,
  input  logic [7:0]        col,
  input  logic [7:0]        row,
  input  logic [7:0]        in_ch0,
  input  logic [7:0]        in_ch1,
  input  logic [7:0]        in_ch2,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_data,
  output logic              out_valid,
  output logic [7:0]        out_col,
  output logic [7:0]        out_row,
  output logic signed [7:0] out_ch0,
  output logic signed [7:0] out_ch1,
  output logic signed [7:0] out_ch2
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_BLEND = 2'd3;

  logic [1:0]        state;
  logic [2:0]        rcnt;
  logic [6:0]        quant_scale;
  logic              accept, div_go, div_done, blend_go, blend_done;
  logic [7:0]        dcol, drow;
  logic [17:0]       sx, sy;
  coord_t            cx, cy;
  logic [7:0]        x1, y1;
  quad_t             quad;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [PIX_W-1:0]  mem_rdata;
  logic [7:0]        rx, ry;
  logic signed [7:0] qv [3];

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      quant_scale <= QUANT_RESET;
    end else if (cfg_we) begin
      quant_scale <= cfg_data;
    end
  end

  // clamp destination coordinate
  assign dcol = ({1'b0, col} > 9'(DEST_WIDTH - 1))  ? 8'(DEST_WIDTH - 1)  : col;
  assign drow = ({1'b0, row} > 9'(DEST_HEIGHT - 1)) ? 8'(DEST_HEIGHT - 1) : row;

  // (2d+1)*SRC - DST, negative maps to zero
  assign sx = 18'(({9'd0, dcol, 1'b1}) * 18'(SOURCE_WIDTH)) - 18'(DEST_WIDTH);
  assign sy = 18'(({9'd0, drow, 1'b1}) * 18'(SOURCE_HEIGHT)) - 18'(DEST_HEIGHT);

  assign div_go = accept && (opcode == OP_COMPUTE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rcnt  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (div_go) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_READ;
            rcnt  <= '0;
          end
        end
        ST_READ: begin
          rcnt <= rcnt + 3'd1;
          if (rcnt == 3'd4) begin
            state <= ST_BLEND;
          end
        end
        ST_BLEND: begin
          if (blend_done) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (div_go) begin
      out_col <= dcol;
      out_row <= drow;
    end
  end

  brnq_coord_div u_div (
    .clk   (clk),
    .rst   (rst),
    .go    (div_go),
    .num_x (sx[17] ? 17'd0 : sx[16:0]),
    .num_y (sy[17] ? 17'd0 : sy[16:0]),
    .done  (div_done),
    .cx    (cx),
    .cy    (cy)
  );

  assign x1 = ({1'b0, cx.i} + 9'd1 < 9'(SOURCE_WIDTH))  ? cx.i + 8'd1 : cx.i;
  assign y1 = ({1'b0, cy.i} + 9'd1 < 9'(SOURCE_HEIGHT)) ? cy.i + 8'd1 : cy.i;

  // neighbor order: p00, p01, p10, p11
  always_comb begin
    rx = cx.i;
    ry = cy.i;
    case (rcnt[1:0])
      2'd1:    rx = x1;
      2'd2:    ry = y1;
      2'd3: begin
        rx = x1;
        ry = y1;
      end
      default: ;
    endcase
  end

  assign mem_we = accept && (opcode == OP_WRITE) &&
                  ({1'b0, col} < 9'(SOURCE_WIDTH)) && ({1'b0, row} < 9'(SOURCE_HEIGHT));

  always_comb begin
    if (state == ST_READ) begin
      mem_addr = ADDR_W'(32'(ry) * 32'(SOURCE_WIDTH) + 32'(rx));
    end else begin
      mem_addr = ADDR_W'(32'(row) * 32'(SOURCE_WIDTH) + 32'(col));
    end
  end

  brnq_frame_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata ({in_ch2, in_ch1, in_ch0}),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      case (rcnt)
        3'd1:    quad.p00 <= mem_rdata;
        3'd2:    quad.p01 <= mem_rdata;
        3'd3:    quad.p10 <= mem_rdata;
        3'd4:    quad.p11 <= mem_rdata;
        default: ;
      endcase
    end
  end

  assign blend_go = (state == ST_READ) && (rcnt == 3'd4);

  // p11 lands on the same edge as blend_go; launch is registered into the next cycle
  logic blend_go_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_go_d <= 1'b0;
    end else begin
      blend_go_d <= blend_go;
    end
  end

  brnq_blend u_blend (
    .clk   (clk),
    .rst   (rst),
    .go    (blend_go_d),
    .px    (quad),
    .fx    (cx.f),
    .fy    (cy.f),
    .scale (quant_scale),
    .done  (blend_done),
    .q     (qv)
  );

  assign out_valid = blend_done;
  assign out_ch0   = qv[0];
  assign out_ch1   = qv[1];
  assign out_ch2   = qv[2];

  a_valid_in_blend: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == ST_BLEND) else $error("result outside blend phase");
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    div_go |=> busy) else $error("compute accepted without going busy");
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == ST_IDLE) else $error("store write while busy");
  a_div_phase: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV) else $error("divider done outside divide phase");

endmodule

@@ rtl/brnq_frame_mem.sv @@
// ----------------------------------------------------------------------------
// brnq_frame_mem
// Single-port frame store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module brnq_frame_mem
  import brnq_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [PIX_W-1:0]  wdata,
  output logic [PIX_W-1:0]  rdata
);

  logic [PIX_W-1:0] mem [0:(1 << ADDR_W) - 1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/brnq_coord_div.sv @@
// ----------------------------------------------------------------------------
// brnq_coord_div
// Source coordinate from destination index: division by the destination size
// through a reciprocal multiply, one register stage, clamped to the frame.
// ----------------------------------------------------------------------------
module brnq_coord_div
  import brnq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [16:0] num_x,
  input  logic [16:0] num_y,
  output logic        done,
  output coord_t      cx,
  output coord_t      cy
);

  // floor(n * 2^15 / DEST) = (n * ceil(2^40 / DEST)) >> 25, exact for n < 2^17
  localparam logic [40:0] RECIP_X =
    41'(((64'd1 << 40) + 64'(DEST_WIDTH) - 64'd1) / 64'(DEST_WIDTH));
  localparam logic [40:0] RECIP_Y =
    41'(((64'd1 << 40) + 64'(DEST_HEIGHT) - 64'd1) / 64'(DEST_HEIGHT));
  localparam logic [32:0] HI_X = 33'((SOURCE_WIDTH - 1) * 65536);
  localparam logic [32:0] HI_Y = 33'((SOURCE_HEIGHT - 1) * 65536);

  logic [57:0] prod_x, prod_y;
  logic [32:0] qx, qy;

  assign prod_x = 58'(num_x) * 58'(RECIP_X);
  assign prod_y = 58'(num_y) * 58'(RECIP_Y);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      qx <= prod_x[57:25];
      qy <= prod_y[57:25];
    end
  end

  assign cx = (qx > HI_X) ? HI_X[COORD_W-1:0] : qx[COORD_W-1:0];
  assign cy = (qy > HI_Y) ? HI_Y[COORD_W-1:0] : qy[COORD_W-1:0];

endmodule

@@ rtl/brnq_blend.sv @@
// ----------------------------------------------------------------------------
// brnq_blend
// Three-lane pipeline: bilinear blend, normalize to [-1,1] at 2^-14,
// scale and truncate toward zero to int8. Six stages.
// ----------------------------------------------------------------------------
module brnq_blend
  import brnq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  quad_t             px,
  input  logic [15:0]       fx,
  input  logic [15:0]       fy,
  input  logic [6:0]        scale,
  output logic              done,
  output logic signed [7:0] q [3]
);

  logic [5:0]         vld;
  logic [16:0]        wx0, wy0, wy0_r, fy_r;
  logic [23:0]        h0 [3];
  logic [23:0]        h1 [3];
  logic [39:0]        s  [3];
  logic [46:0]        pr [3];
  logic signed [23:0] qp [3];
  logic [16:0]        nq [3];

  assign wx0 = 17'h10000 - {1'b0, fx};
  assign wy0 = 17'h10000 - {1'b0, fy};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], go};
    end
  end

  assign done = vld[5];

  always_ff @(posedge clk) begin
    wy0_r <= wy0;
    fy_r  <= {1'b0, fy};
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    always_ff @(posedge clk) begin
      h0[c] <= 24'(px.p00[8*c +: 8] * wx0) + 24'(px.p01[8*c +: 8] * fx);
      h1[c] <= 24'(px.p10[8*c +: 8] * wx0) + 24'(px.p11[8*c +: 8] * fx);
      s[c]  <= 40'(h0[c] * wy0_r) + 40'(h1[c] * fy_r);
      pr[c] <= 47'(s[c][39:17] * RECIP_255);
      nq[c] <= pr[c][46:RECIP_SHIFT] - NORM_OFFSET;
      qp[c] <= 24'($signed(nq[c]) * $signed({1'b0, scale}));
      // truncate toward zero
      if (qp[c] < 0) begin
        q[c] <= 8'((qp[c] + 24'sd16383) >>> 14);
      end else begin
        q[c] <= 8'(qp[c] >>> 14);
      end
    end
  end

endmodule
